[sv/tsct_pkg.sv]
// Shared widths, codes and constants of the throttle-scaled countdown timer.
`default_nettype none

package tsct_pkg;

  // Payload field widths
  localparam int NOW_W   = 32;
  localparam int THR_W   = 8;
  localparam int COUNT_W = 22;
  localparam int SEC_W   = 12;
  localparam int SND_W   = 2;

  // Stream and configuration port widths
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;

  // Shared divider: dividend width, divisor width, step counter width
  localparam int DIV_W = 40;
  localparam int DVS_W = 10;
  localparam int DCNT_W = 5;
  localparam int PCT_W = 7;

  // Parameter defaults
  localparam int MS_PER_SECOND_DEF = 1000;
  localparam int MIN_STEP_MS_DEF   = 100;

  // Fixed constants of the algorithm
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [DVS_W-1:0] MINUTE    = 10'd60;
  localparam logic [SEC_W-1:0] BEEP_SECS = 12'd10;
  localparam logic [SEC_W-1:0] SEC_MAX   = 12'hFFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_SECONDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_DEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_MIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_MAX  = 2'd3;

  // Sound codes
  localparam logic [SND_W-1:0] SND_NONE   = 2'd0;
  localparam logic [SND_W-1:0] SND_ZERO   = 2'd1;
  localparam logic [SND_W-1:0] SND_SECOND = 2'd2;
  localparam logic [SND_W-1:0] SND_MINUTE = 2'd3;

  // Divider jobs
  typedef logic [2:0] div_op_t;
  localparam div_op_t OP_PCT  = 3'd0;
  localparam div_op_t OP_DYN  = 3'd1;
  localparam div_op_t OP_BACK = 3'd2;
  localparam div_op_t OP_SEC  = 3'd3;
  localparam div_op_t OP_MIN  = 3'd4;

endpackage

`default_nettype wire

[sv/throttle_scaled_countdown_timer.sv]
// Throttle-scaled countdown timer with a shared serial divider.
`default_nettype none

// A reset beat (tuser high) loads start_seconds * MS_PER_SECOND and stops the
// timer; an update beat carries the millisecond clock, throttle and switch.
// Every input beat yields one result beat. Divisions run on one shared
// restoring divider that retires two quotient bits per cycle; it runs up to
// five jobs per item: rate percent, elapsed scaling, anchor rescale, whole
// seconds and minute mark. in_tready is high only while the sequencer is
// idle; a finished result waits in the output register without blocking the
// next beat.
module throttle_scaled_countdown_timer
  import tsct_pkg::*;
#(
  parameter int MS_PER_SECOND = MS_PER_SECOND_DEF,
  parameter int MIN_STEP_MS   = MIN_STEP_MS_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  // [31:0] now_ms, [39:32] throttle_pct, [40] switch_on, [47:41] zero
  input  wire  [IN_TDATA_W-1:0]   in_tdata,
  // [0] req_type
  input  wire  [IN_TUSER_W-1:0]   in_tuser,
  output logic                    out_tvalid,
  input  wire                     out_tready,
  // [21:0] remaining_ms, [33:22] remaining_sec, [35:34] sound, [36] updated,
  // [39:37] zero
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire  [CFG_IDX_W-1:0]    cfg_index,
  input  wire  [CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PCT   = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_POST  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_BACK  = 4'd6;
  localparam logic [3:0] S_SEC   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam logic [DVS_W-1:0] MS_C   = DVS_W'(MS_PER_SECOND);
  localparam logic [NOW_W-1:0] STEP_C = NOW_W'(MIN_STEP_MS);

  // Configuration
  logic [SEC_W-1:0]        start_r;
  logic                    dep_r;
  logic signed [THR_W-1:0] tmin_r;
  logic signed [THR_W-1:0] tmax_r;

  // Captured item
  logic                    req_r, req_nxt;
  logic [NOW_W-1:0]        now_r, now_nxt;
  logic signed [THR_W-1:0] thr_r, thr_nxt;
  logic                    sw_r, sw_nxt;

  // Timer state and work registers
  logic [3:0]         state_r, state_nxt;
  div_op_t            op_r, op_nxt;
  logic [PCT_W-1:0]   pct_r, pct_nxt;
  logic [NOW_W-1:0]   diff_r, diff_nxt;
  logic [NOW_W-1:0]   dyn_r, dyn_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [NOW_W-1:0]   anchor_r, anchor_nxt;
  logic               run_r, run_nxt;
  logic [SEC_W-1:0]   shown_r, shown_nxt;
  logic [SND_W-1:0]   sound_r, sound_nxt;
  logic               upd_r, upd_nxt;

  // Divider
  logic [DIV_W-1:0]   dq_r, dq_nxt;
  logic [DVS_W-1:0]   dr_r, dr_nxt;
  logic [DVS_W-1:0]   dd_r, dd_nxt;
  logic [DCNT_W-1:0]  dc_r, dc_nxt;
  logic [DVS_W:0]     t1, t2;
  logic [DIV_W-1:0]   q1, q2;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Combinational helpers
  logic signed [THR_W-1:0] thr_lo, thr_c;
  logic signed [THR_W:0]   den, num;
  logic [15:0]             num_x100;
  logic [SEC_W+DVS_W-1:0]  load_prod;
  logic [DIV_W-1:0]        mul_prod;
  logic [DIV_W-1:0]        back_num;
  logic [COUNT_W-1:0]      secs;
  logic [SEC_W-1:0]        secs_sat;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Two restoring steps per cycle
  always_comb begin
    t1 = {dr_r, dq_r[DIV_W-1]};
    q1 = {dq_r[DIV_W-2:0], 1'b0};
    if (t1 >= {1'b0, dd_r}) begin
      t1 = t1 - {1'b0, dd_r};
      q1[0] = 1'b1;
    end
    t2 = {t1[DVS_W-1:0], q1[DIV_W-1]};
    q2 = {q1[DIV_W-2:0], 1'b0};
    if (t2 >= {1'b0, dd_r}) begin
      t2 = t2 - {1'b0, dd_r};
      q2[0] = 1'b1;
    end
  end

  always_comb begin
    thr_lo    = (thr_r < tmin_r) ? tmin_r : thr_r;
    thr_c     = (thr_lo > tmax_r) ? tmax_r : thr_lo;
    den       = {tmax_r[THR_W-1], tmax_r} - {tmin_r[THR_W-1], tmin_r};
    num       = {thr_c[THR_W-1], thr_c} - {tmin_r[THR_W-1], tmin_r};
    num_x100  = {2'b0, num[7:0], 6'b0} + {3'b0, num[7:0], 5'b0} +
                {6'b0, num[7:0], 2'b0};
    load_prod = {{DVS_W{1'b0}}, start_r} * {{SEC_W{1'b0}}, MS_C};
    mul_prod  = {{(DIV_W-NOW_W){1'b0}}, diff_r} * {{(DIV_W-PCT_W){1'b0}}, pct_r};
    back_num  = {{(DIV_W-NOW_W){1'b0}}, dyn_r} * {{(DIV_W-PCT_W){1'b0}}, PCT_FULL};
    secs      = dq_r[COUNT_W-1:0];
    secs_sat  = (secs > {{(COUNT_W-SEC_W){1'b0}}, SEC_MAX}) ? SEC_MAX : secs[SEC_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    req_nxt       = req_r;
    now_nxt       = now_r;
    thr_nxt       = thr_r;
    sw_nxt        = sw_r;
    pct_nxt       = pct_r;
    diff_nxt      = diff_r;
    dyn_nxt       = dyn_r;
    count_nxt     = count_r;
    anchor_nxt    = anchor_r;
    run_nxt       = run_r;
    shown_nxt     = shown_r;
    sound_nxt     = sound_r;
    upd_nxt       = upd_r;
    dq_nxt        = dq_r;
    dr_nxt        = dr_r;
    dd_nxt        = dd_r;
    dc_nxt        = dc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt   = in_tuser[0];
          now_nxt   = in_tdata[31:0];
          thr_nxt   = $signed(in_tdata[39:32]);
          sw_nxt    = in_tdata[40];
          sound_nxt = SND_NONE;
          upd_nxt   = 1'b0;
          state_nxt = S_PCT;
        end
      end

      S_PCT: begin
        if (req_r) begin
          count_nxt  = load_prod[COUNT_W-1:0];
          anchor_nxt = '0;
          run_nxt    = 1'b0;
          state_nxt  = S_OUT;
        end else if (!dep_r || den < 0) begin
          // dependence off, or crossed limits that clamp to the upper limit: full rate
          pct_nxt   = PCT_FULL;
          state_nxt = S_CHECK;
        end else if (den == 0) begin
          pct_nxt   = '0;
          state_nxt = S_CHECK;
        end else begin
          dq_nxt    = {num_x100, {(DIV_W-16){1'b0}}};
          dr_nxt    = '0;
          dd_nxt    = {{(DVS_W-8){1'b0}}, den[7:0]};
          dc_nxt    = DCNT_W'(8);
          op_nxt    = OP_PCT;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        dq_nxt = q2;
        dr_nxt = t2[DVS_W-1:0];
        dc_nxt = dc_r - DCNT_W'(1);
        if (dc_r == DCNT_W'(1)) begin
          state_nxt = S_POST;
        end
      end

      S_CHECK: begin
        if (sw_r && count_r != '0 && pct_r != '0) begin
          if (!run_r) begin
            anchor_nxt = now_r;
            run_nxt    = 1'b1;
            state_nxt  = S_OUT;
          end else if ((now_r - anchor_r) >= STEP_C) begin
            diff_nxt  = now_r - anchor_r;
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_OUT;
          end
        end else begin
          run_nxt   = 1'b0;
          state_nxt = S_OUT;
        end
      end

      S_MUL: begin
        dq_nxt    = mul_prod;
        dr_nxt    = '0;
        dd_nxt    = {{(DVS_W-PCT_W){1'b0}}, PCT_FULL};
        dc_nxt    = DCNT_W'(DIV_W / 2);
        op_nxt    = OP_DYN;
        state_nxt = S_DIV;
      end

      S_BACK: begin
        dq_nxt    = back_num;
        dr_nxt    = '0;
        dd_nxt    = {{(DVS_W-PCT_W){1'b0}}, pct_r};
        dc_nxt    = DCNT_W'(DIV_W / 2);
        op_nxt    = OP_BACK;
        state_nxt = S_DIV;
      end

      S_SEC: begin
        dq_nxt    = {count_r, {(DIV_W-COUNT_W){1'b0}}};
        dr_nxt    = '0;
        dd_nxt    = MS_C;
        dc_nxt    = DCNT_W'(COUNT_W / 2);
        op_nxt    = OP_SEC;
        state_nxt = S_DIV;
      end

      S_POST: begin
        case (op_r)
          OP_PCT: begin
            pct_nxt   = dq_r[PCT_W-1:0];
            state_nxt = S_CHECK;
          end
          OP_DYN: begin
            dyn_nxt = dq_r[NOW_W-1:0];
            if (dq_r >= {{(DIV_W-COUNT_W){1'b0}}, count_r}) begin
              count_nxt = '0;
            end else begin
              count_nxt = count_r - dq_r[COUNT_W-1:0];
            end
            upd_nxt   = 1'b1;
            state_nxt = S_BACK;
          end
          OP_BACK: begin
            anchor_nxt = anchor_r + dq_r[NOW_W-1:0];
            state_nxt  = S_SEC;
          end
          OP_SEC: begin
            shown_nxt = secs_sat;
            state_nxt = S_OUT;
            if (count_r == '0) begin
              sound_nxt = SND_ZERO;
            end else if (shown_r != secs_sat) begin
              if (secs_sat < BEEP_SECS) begin
                sound_nxt = SND_SECOND;
              end else begin
                // minute mark: check (seconds + 1) mod 60 next
                state_nxt = S_DIV;
                dq_nxt    = {1'b0, {1'b0, secs_sat} + {{SEC_W{1'b0}}, 1'b1},
                             {(DIV_W-SEC_W-2){1'b0}}};
                dr_nxt    = '0;
                dd_nxt    = MINUTE;
                dc_nxt    = DCNT_W'((SEC_W + 2) / 2);
                op_nxt    = OP_MIN;
              end
            end
          end
          OP_MIN: begin
            if (dr_r == '0) begin
              sound_nxt = SND_MINUTE;
            end
            state_nxt = S_OUT;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b0, upd_r, sound_r, shown_r, count_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      dep_r   <= 1'b0;
      tmin_r  <= -8'sd100;
      tmax_r  <= 8'sd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START_SECONDS: start_r <= cfg_data[SEC_W-1:0];
        CFG_THROTTLE_DEP:  dep_r   <= cfg_data[0];
        CFG_THROTTLE_MIN:  tmin_r  <= $signed(cfg_data[THR_W-1:0]);
        CFG_THROTTLE_MAX:  tmax_r  <= $signed(cfg_data[THR_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      anchor_r    <= '0;
      run_r       <= 1'b0;
      shown_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      anchor_r    <= anchor_nxt;
      run_r       <= run_nxt;
      shown_r     <= shown_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    req_r      <= req_nxt;
    now_r      <= now_nxt;
    thr_r      <= thr_nxt;
    sw_r       <= sw_nxt;
    pct_r      <= pct_nxt;
    diff_r     <= diff_nxt;
    dyn_r      <= dyn_nxt;
    sound_r    <= sound_nxt;
    upd_r      <= upd_nxt;
    dq_r       <= dq_nxt;
    dr_r       <= dr_nxt;
    dd_r       <= dd_nxt;
    dc_r       <= dc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
